[sv/regex_infix_to_postfix_defines.svh]
// Assertion macros shared by the checking code of the converter.
`ifndef REGEX_INFIX_TO_POSTFIX_DEFINES_SVH
`define REGEX_INFIX_TO_POSTFIX_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RITP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/ritp_pkg.sv]
package ritp_pkg;

    localparam int RITP_STACK_DEPTH = 32;

    // Characters the converter acts on.
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Stack entry codes; for the operators the code is also the precedence.
    typedef enum logic [1:0] {
        OP_OPEN = 2'd0,
        OP_BAR  = 2'd1,
        OP_DOT  = 2'd2,
        OP_STAR = 2'd3
    } op_code_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_STRAY     = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_UNMATCHED = 2'd3
    } err_code_t;

    typedef enum logic [2:0] {
        CLS_LETTER,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_BAR,
        CLS_DOT,
        CLS_STAR,
        CLS_OTHER
    } sym_class_t;

    typedef enum logic [1:0] {
        SEL_LETTER,
        SEL_OP,
        SEL_MARK
    } emit_sel_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expr;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       is_marker;
        logic [1:0] error_code;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic      latch;
        logic      emit;
        emit_sel_t sel;
        logic      push;
        op_code_t  push_code;
        logic      pop;
        logic      set_err;
        err_code_t err_code;
        logic      clear_err;
        logic      finish;
    } ctrl_cmd_t;

    typedef struct packed {
        sym_class_t cls;
        logic       end_flag;
        logic       empty;
        op_code_t   top;
        logic       pend_valid;
        logic       out_free;
    } dp_status_t;

    function automatic sym_class_t classify(input logic [7:0] sym);
        sym_class_t c;
        begin
            c = CLS_OTHER;
            if ((sym >= CH_UP_A && sym <= CH_UP_Z) || (sym >= CH_LO_A && sym <= CH_LO_Z))
            begin
                c = CLS_LETTER;
            end
            else if (sym == CH_LPAREN)
            begin
                c = CLS_OPEN;
            end
            else if (sym == CH_RPAREN)
            begin
                c = CLS_CLOSE;
            end
            else if (sym == CH_BAR)
            begin
                c = CLS_BAR;
            end
            else if (sym == CH_DOT)
            begin
                c = CLS_DOT;
            end
            else if (sym == CH_STAR)
            begin
                c = CLS_STAR;
            end
            return c;
        end
    endfunction

    function automatic logic [7:0] code_char(input op_code_t op);
        logic [7:0] ch;
        begin
            case (op)
                OP_OPEN: ch = CH_LPAREN;
                OP_BAR:  ch = CH_BAR;
                OP_DOT:  ch = CH_DOT;
                OP_STAR: ch = CH_STAR;
                default: ch = CH_NUL;
            endcase
            return ch;
        end
    endfunction

endpackage

[sv/ritp_ctrl.sv]
module ritp_ctrl
    import ritp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sym_valid,
    output logic       sym_stall,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t   state_reg;
    state_t   state_next;
    logic     can_emit;
    logic     can_pop;
    op_code_t prec;

    // A new result may enter the pending slot once the old one can move on.
    assign can_emit = !st.pend_valid || st.out_free;
    assign prec     = (st.cls == CLS_DOT) ? OP_DOT : OP_BAR;
    assign can_pop  = !st.empty && (st.top >= prec);

    assign sym_stall = !((state_reg == ST_IDLE) && can_emit);

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = SEL_LETTER;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.finish = st.pend_valid && st.out_free;
                if (sym_valid && can_emit)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (st.cls)
                    CLS_LETTER:
                    begin
                        if (can_emit)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.sel    = SEL_LETTER;
                            state_next = st.end_flag ? ST_FLUSH : ST_IDLE;
                        end
                    end
                    CLS_OPEN, CLS_STAR:
                    begin
                        cmd.push      = 1'b1;
                        cmd.push_code = (st.cls == CLS_OPEN) ? OP_OPEN : OP_STAR;
                        state_next    = st.end_flag ? ST_FLUSH : ST_IDLE;
                    end
                    CLS_CLOSE, CLS_BAR, CLS_DOT:
                    begin
                        if (can_pop)
                        begin
                            if (can_emit)
                            begin
                                cmd.emit = 1'b1;
                                cmd.sel  = SEL_OP;
                                cmd.pop  = 1'b1;
                            end
                        end
                        else
                        begin
                            if (st.cls == CLS_CLOSE)
                            begin
                                cmd.pop      = !st.empty;
                                cmd.set_err  = st.empty;
                                cmd.err_code = ERR_STRAY;
                            end
                            else
                            begin
                                cmd.push      = 1'b1;
                                cmd.push_code = (st.cls == CLS_DOT) ? OP_DOT : OP_BAR;
                            end
                            state_next = st.end_flag ? ST_FLUSH : ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = st.end_flag ? ST_FLUSH : ST_IDLE;
                    end
                endcase
            end
            ST_FLUSH:
            begin
                if (can_emit)
                begin
                    cmd.emit = 1'b1;
                    if (!st.empty)
                    begin
                        cmd.sel      = SEL_OP;
                        cmd.pop      = 1'b1;
                        cmd.set_err  = (st.top == OP_OPEN);
                        cmd.err_code = ERR_UNMATCHED;
                    end
                    else
                    begin
                        cmd.sel       = SEL_MARK;
                        cmd.clear_err = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/ritp_dpath.sv]
module ritp_dpath
    import ritp_pkg::*;
#(
    parameter int STACK_DEPTH = RITP_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   sym_data,
    output logic       res_valid,
    input  logic       res_stall,
    output out_item_t  res_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t st
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    op_code_t        stack_mem [STACK_DEPTH];
    op_code_t        mem_rd_reg;
    op_code_t        byp_reg;
    logic            byp_sel_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   count_m1;
    logic [AW-1:0]   rd_addr;
    logic            full;
    logic            overflow;
    logic            do_write;
    logic [7:0]      sym_reg;
    logic            end_reg;
    err_code_t       sticky_reg;
    err_code_t       err_req;
    err_code_t       err_now;
    op_code_t        top;
    logic            pend_valid_reg;
    out_item_t       pend_reg;
    out_item_t       new_item;
    out_item_t       move_item;
    logic            res_valid_reg;
    out_item_t       res_reg;
    logic            out_free;
    logic            move;

    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign overflow = cmd.push && full;
    assign do_write = cmd.push && !full;

    always_comb
    begin
        count_next = count_reg;
        if (do_write)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // The read port always fetches the entry that will be on top next cycle.
    assign count_m1 = count_next - CW'(1);
    assign rd_addr  = count_m1[AW-1:0];
    assign top      = byp_sel_reg ? byp_reg : mem_rd_reg;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            stack_mem[count_reg[AW-1:0]] <= cmd.push_code;
        end
        mem_rd_reg <= stack_mem[rd_addr];
        byp_reg    <= cmd.push_code;
        if (cmd.latch)
        begin
            sym_reg <= sym_data.symbol;
            end_reg <= sym_data.end_of_expr;
        end
    end

    // The first error of an expression wins.
    always_comb
    begin
        err_req = ERR_NONE;
        if (cmd.set_err)
        begin
            err_req = cmd.err_code;
        end
        else if (overflow)
        begin
            err_req = ERR_OVERFLOW;
        end
        err_now = (sticky_reg != ERR_NONE) ? sticky_reg : err_req;
    end

    always_comb
    begin
        new_item            = '0;
        new_item.error_code = err_now;
        case (cmd.sel)
            SEL_LETTER: new_item.out_symbol = sym_reg;
            SEL_OP:     new_item.out_symbol = code_char(top);
            SEL_MARK:
            begin
                new_item.out_symbol = CH_NUL;
                new_item.is_marker  = 1'b1;
            end
            default:    new_item.out_symbol = CH_NUL;
        endcase
    end

    assign out_free = !res_valid_reg || !res_stall;
    assign move     = pend_valid_reg && (cmd.emit || cmd.finish);

    // The pending result leaves with last set only when its request completes.
    always_comb
    begin
        move_item      = pend_reg;
        move_item.last = cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_reg <= new_item;
        end
        if (move)
        begin
            res_reg <= move_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            sticky_reg     <= ERR_NONE;
            byp_sel_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            sticky_reg     <= cmd.clear_err ? ERR_NONE : err_now;
            byp_sel_reg    <= do_write;
            pend_valid_reg <= cmd.emit || (pend_valid_reg && !cmd.finish);
            res_valid_reg  <= move || (res_valid_reg && res_stall);
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    assign st.cls        = classify(sym_reg);
    assign st.end_flag   = end_reg;
    assign st.empty      = (count_reg == '0);
    assign st.top        = top;
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = out_free;

endmodule

[sv/regex_infix_to_postfix.sv]
// Converts a regular expression, fed one ASCII character per request, into
// its postfix form with an operator stack (shunting-yard). Letters pass
// straight to the output; '(' and '*' are pushed; '|' and '.' first pop
// operators of equal or higher precedence down to a '(' and are then pushed;
// ')' pops operators down to its '(' and drops it. Any other character is
// ignored. On a request marked end_of_expr the stack is flushed top first,
// leftover '(' included, and a marker result with the expression's first
// error code ends the output of that expression. The last result caused by
// each request carries last set. A letter, '(', '*' or ignored character
// goes from idle to execute and back; '|', '.' and ')' stay in execute while
// they pop operators, and end_of_expr then flushes each stack entry and emits
// the marker in the flush state. The stack memory has one write port and one
// registered read port, so one entry is popped per cycle while results move
// on; a stalled full result register holds the converter until it is taken.
module regex_infix_to_postfix
    import ritp_pkg::*;
#(
    parameter int STACK_DEPTH = RITP_STACK_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sym_valid,
    output logic      sym_stall,
    input  in_item_t  sym_data,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_data
);

    // The controller sequences each request; the datapath holds the stack,
    // the sticky error, a pending result and the output register.
    ctrl_cmd_t  cmd;
    dp_status_t st;

    // The controller issues one command word per cycle and reads back the
    // class of the held character, the stack top and the output status.
    ritp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // The newest result waits in a pending slot until the next one appears or
    // the request completes, which decides its last flag.
    ritp_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_data  (sym_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

[sv/ritp_checker.sv]
`include "regex_infix_to_postfix_defines.svh"

module ritp_checker
    import ritp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      sym_valid,
    input logic      sym_stall,
    input in_item_t  sym_data,
    input logic      res_valid,
    input logic      res_stall,
    input out_item_t res_data
);

    `RITP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)

    // One request at a time: the cycle after an accept is always busy.
    `RITP_ASSERT_NEXT(a_busy_after_accept, sym_valid && !sym_stall, sym_stall)

    `RITP_ASSERT_IMPL(a_marker_shape, res_valid && res_data.is_marker, res_data.last && (res_data.out_symbol == CH_NUL))

    `RITP_ASSERT_IMPL(a_symbol_legal, res_valid && !res_data.is_marker, (res_data.out_symbol >= CH_UP_A && res_data.out_symbol <= CH_UP_Z) || (res_data.out_symbol >= CH_LO_A && res_data.out_symbol <= CH_LO_Z) || (res_data.out_symbol == CH_LPAREN) || (res_data.out_symbol == CH_BAR) || (res_data.out_symbol == CH_DOT) || (res_data.out_symbol == CH_STAR))

endmodule

bind regex_infix_to_postfix ritp_checker u_ritp_checker (.*);
